>>> design/strast_pkg.sv
package strast_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PAGE_COUNT * DISPLAY_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int ROWS_PAD    = PAGE_COUNT * 8;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_STEP = 6;
   localparam int MAX_SCALE  = 7;
   localparam int MAX_LEN    = 64;
   localparam int MAX_INDEX  = 63;

   // scaled glyph column, before placement
   localparam int EXP_W = GLYPH_ROWS * MAX_SCALE;
   // string width and left edge
   localparam int WID_W = $clog2(MAX_LEN * GLYPH_STEP * MAX_SCALE + DISPLAY_WIDTH + 1);
   // running pixel column, with room to step past the right edge
   localparam int XW = $clog2(DISPLAY_WIDTH + MAX_INDEX * GLYPH_STEP * MAX_SCALE
                              + 2 * GLYPH_STEP * MAX_SCALE + 1);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [6:0] DIGIT_FONT [10][GLYPH_COLS] = '{
      '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}, '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
      '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
      '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
      '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
      '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}
   };

   localparam logic [6:0] LETTER_FONT [26][GLYPH_COLS] = '{
      '{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
      '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
      '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
      '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A}, '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
      '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01},
      '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
      '{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}, '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F},
      '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
      '{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}, '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46},
      '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
      '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
      '{7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
      '{7'h03, 7'h04, 7'h78, 7'h04, 7'h03}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}
   };

   function automatic logic [6:0] font_column(logic [7:0] code, logic [2:0] col);
      logic [6:0] bits;
      bits = '0;
      if (col < 3'(GLYPH_COLS)) begin
         if (code >= 8'h30 && code <= 8'h39) begin
            bits = DIGIT_FONT[4'(code - 8'h30)][col];
         end else if (code >= 8'h41 && code <= 8'h5A) begin
            bits = LETTER_FONT[5'(code - 8'h41)][col];
         end
      end
      return bits;
   endfunction

   // stretch a 7-row glyph column by scale; one wired pattern per scale
   function automatic logic [EXP_W-1:0] expand_column(logic [6:0] bits,
                                                      logic [2:0] scale);
      logic [EXP_W-1:0] e;
      e = '0;
      for (int s = 1; s <= MAX_SCALE; s++) begin
         if (int'(scale) == s) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
               for (int d = 0; d < s; d++) begin
                  e[r * s + d] = bits[r];
               end
            end
         end
      end
      return e;
   endfunction

   function automatic logic [ROWS_PAD-1:0] row_mask();
      logic [ROWS_PAD-1:0] m;
      for (int y = 0; y < ROWS_PAD; y++) begin
         m[y] = (y < DISPLAY_HEIGHT);
      end
      return m;
   endfunction

endpackage

>>> design/scaled_text_rasterizer_core.sv
// channel | dir | ports
// --------+-----+------------------------------------------------------------
// req     | in  | req_valid, req_stall, req_operation, req_char_code,
//         |     | req_char_index, req_text_length, req_text_y, req_scale,
//         |     | req_read_address
// rsp     | out | rsp_valid, rsp_stall, rsp_read_data (read items only)
//
// One item at a time through a sequencer around a single-port frame RAM.
// Clear: one RAM write per byte, STORE_BYTES (1024) bytes. Draw: ST_SETUP_SIZE,
// ST_SETUP_X, then per glyph column and per pixel column on screen each of the
// PAGE_COUNT (8) pages, plus ST_RMW per touched page (read-modify-write port).
// Reset starts the same clearing pass; req_stall is high during it. A read
// result waits in the output register; clears and draws go on meanwhile.
module scaled_text_rasterizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_char_index,
   input  logic [6:0] req_text_length,
   input  logic [5:0] req_text_y,
   input  logic [2:0] req_scale,
   input  logic [9:0] req_read_address,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data
);

   import strast_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_READ_WAIT,
      ST_SETUP_SIZE,
      ST_SETUP_X,
      ST_COLUMN,
      ST_PAGE,
      ST_RMW
   } state_type;

   localparam logic [ROWS_PAD-1:0] ROW_MASK = row_mask();

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [7:0]          code_ff, code_in;
   logic [5:0]          pos_ff, pos_in;
   logic [6:0]          len_ff, len_in;
   logic [5:0]          top_ff, top_in;
   logic [2:0]          scale_ff, scale_in;
   logic [WID_W-1:0]    width_ff, width_in;
   logic [XW-1:0]       pos_off_ff, pos_off_in;
   logic [XW-1:0]       x_ff, x_in;
   logic [2:0]          col_ff, col_in;
   logic [2:0]          dx_ff, dx_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [ROWS_PAD-1:0] colvec_ff, colvec_in;
   logic [7:0]          mask_ff, mask_in;
   logic [ADDR_W-1:0]   rmw_addr_ff, rmw_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]   ram_addr;
   logic                ram_we;
   logic [7:0]          ram_wdata;
   logic [7:0]          ram_rdata;

   logic [5:0]          s6;
   logic [6:0]          glyph;
   logic [XW-1:0]       left;
   logic [7:0]          page_mask;
   logic [ADDR_W-1:0]   page_addr;
   logic                step_page;

   strast_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_frame (
      .clock   (clock),
      .addr    (ram_addr),
      .wr_en   (ram_we),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign s6        = 6'(GLYPH_STEP * int'(scale_ff));
   assign glyph     = font_column(code_ff, col_ff);
   assign page_mask = colvec_ff[page_ff*8 +: 8];
   assign page_addr = ADDR_W'(int'(page_ff) * DISPLAY_WIDTH) + ADDR_W'(x_ff);

   always_comb begin
      if (width_ff < WID_W'(DISPLAY_WIDTH)) begin
         left = XW'((WID_W'(DISPLAY_WIDTH) - width_ff) >> 1);
      end else begin
         left = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rd_addr_in   = rd_addr_ff;
      rd_ok_in     = rd_ok_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      top_in       = top_ff;
      scale_in     = scale_ff;
      width_in     = width_ff;
      pos_off_in   = pos_off_ff;
      x_in         = x_ff;
      col_in       = col_ff;
      dx_in        = dx_ff;
      page_in      = page_ff;
      colvec_in    = colvec_ff;
      mask_in      = mask_ff;
      rmw_addr_in  = rmw_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_addr     = rd_addr_ff;
      ram_we       = 1'b0;
      ram_wdata    = ram_rdata | mask_ff;
      step_page    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  OP_DRAW: begin
                     code_in  = req_char_code;
                     pos_in   = req_char_index;
                     len_in   = req_text_length;
                     top_in   = req_text_y;
                     scale_in = req_scale;
                     if (req_text_length != 7'd0 && req_scale != 3'd0) begin
                        state_in = ST_SETUP_SIZE;
                     end
                  end
                  OP_READ: begin
                     rd_addr_in = ADDR_W'(req_read_address);
                     rd_ok_in   = (32'(req_read_address) < STORE_BYTES);
                     state_in   = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            ram_addr  = clr_cnt_ff;
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            // RAM address holds, so the read data stays until the slot frees
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ok_ff ? ram_rdata : 8'h00;
               state_in     = ST_IDLE;
            end
         end
         ST_SETUP_SIZE: begin
            width_in   = WID_W'(len_ff) * WID_W'(s6) - WID_W'(scale_ff);
            pos_off_in = XW'(pos_ff) * XW'(s6);
            state_in   = ST_SETUP_X;
         end
         ST_SETUP_X: begin
            x_in     = left + pos_off_ff;
            col_in   = '0;
            dx_in    = '0;
            state_in = ST_COLUMN;
         end
         ST_COLUMN: begin
            if (glyph == 7'd0) begin
               // blank column: skip its pixel columns at once
               x_in = x_ff + XW'(scale_ff);
               if (col_ff == 3'(GLYPH_COLS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               colvec_in = (ROWS_PAD'(expand_column(glyph, scale_ff)) << top_ff)
                           & ROW_MASK;
               page_in   = '0;
               state_in  = ST_PAGE;
            end
         end
         ST_PAGE: begin
            if (x_ff >= XW'(DISPLAY_WIDTH)) begin
               // x only grows, so the rest of the item is off screen
               state_in = ST_IDLE;
            end else if (page_mask != 8'h00) begin
               ram_addr    = page_addr;
               rmw_addr_in = page_addr;
               mask_in     = page_mask;
               state_in    = ST_RMW;
            end else begin
               step_page = 1'b1;
            end
         end
         ST_RMW: begin
            ram_addr  = rmw_addr_ff;
            ram_we    = 1'b1;
            step_page = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (step_page) begin
         if (page_ff == PAGE_W'(PAGE_COUNT - 1)) begin
            page_in = '0;
            x_in    = x_ff + 1'b1;
            if (dx_ff == scale_ff - 3'd1) begin
               dx_in = '0;
               if (col_ff == 3'(GLYPH_COLS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_COLUMN;
               end
            end else begin
               dx_in    = dx_ff + 1'b1;
               state_in = ST_PAGE;
            end
         end else begin
            page_in  = page_ff + 1'b1;
            state_in = ST_PAGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff  <= rd_addr_in;
      rd_ok_ff    <= rd_ok_in;
      code_ff     <= code_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      top_ff      <= top_in;
      scale_ff    <= scale_in;
      width_ff    <= width_in;
      pos_off_ff  <= pos_off_in;
      x_ff        <= x_in;
      col_ff      <= col_in;
      dx_ff       <= dx_in;
      page_ff     <= page_in;
      colvec_ff   <= colvec_in;
      mask_ff     <= mask_in;
      rmw_addr_ff <= rmw_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

>>> design/strast_ram.sv
module strast_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
